// ----- rtl/dual_wheel_pi_speed_regulator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual-wheel PI speed regulator
// Two shorthands for clocked implications with a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PI_SPEED_REGULATOR_ASSERT_SVH
`define DUAL_WHEEL_PI_SPEED_REGULATOR_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define DWPI_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dwpi: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define DWPI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dwpi: next-cycle check failed");

`endif

// ----- rtl/dwpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dwpi_pkg
// Widths, constants, stage types and per-wheel arithmetic of the regulator.
// ----------------------------------------------------------------------------
package dwpi_pkg;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int LIMIT_W    = 7;
    localparam int FIELD_W    = 16;
    localparam int DRIVE_W    = 8;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int SUM_W      = 32;
    localparam int X_W        = 34;
    localparam int MAG_W      = 12;
    localparam int PROD_W     = 24;

    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = 7'd100;

    // Saturation bound of the error sum, held one bit wider for the raw add.
    localparam logic signed [SUM_W:0] SUM_HI = 33'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI;

    // |25*err + 2*sum| at or above this gives a quotient beyond 127.
    localparam logic [X_W-1:0]    BIG_THRESH  = 34'd3200;
    // ceil(2^16 / 25): exact floor division for magnitudes below 4681.
    localparam logic [PROD_W-1:0] RECIP_25    = 24'd2622;
    localparam int                RECIP_SHIFT = 16;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
    } wheel_mid_t;

    typedef struct packed {
        logic             big;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } wheel_frac_t;

    // trunc((cmd - 2*ticks) / 2) toward zero.
    function automatic logic signed [ERR_W-1:0] wheel_error(
        input logic signed [FIELD_W-1:0] cmd,
        input logic signed [FIELD_W-1:0] ticks
    );
        logic signed [DIFF_W-1:0] diff;
        diff = {{2{cmd[FIELD_W-1]}}, cmd} - {ticks[FIELD_W-1], ticks, 1'b0};
        diff = diff + {{(DIFF_W-1){1'b0}}, diff[DIFF_W-1]};
        return diff[DIFF_W-1:1];
    endfunction

    // Command sign strictly opposite to the sum sign.
    function automatic logic opposes(
        input logic signed [SUM_W-1:0]   sum,
        input logic signed [FIELD_W-1:0] cmd
    );
        logic sum_pos;
        logic cmd_pos;
        sum_pos = !sum[SUM_W-1] && (sum != '0);
        cmd_pos = !cmd[FIELD_W-1] && (cmd != '0);
        return (sum_pos && cmd[FIELD_W-1]) || (sum[SUM_W-1] && cmd_pos);
    endfunction

    function automatic logic signed [SUM_W-1:0] sum_update(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [ERR_W-1:0] err,
        input logic                    clear
    );
        logic signed [SUM_W:0] base;
        logic signed [SUM_W:0] total;
        base  = clear ? '0 : {sum[SUM_W-1], sum};
        total = base + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (total > SUM_HI) begin
            return SUM_HI[SUM_W-1:0];
        end else if (total < SUM_LO) begin
            return SUM_LO[SUM_W-1:0];
        end
        return total[SUM_W-1:0];
    endfunction

    // Form 25*err + 2*sum and split it into sign, overflow and magnitude.
    function automatic wheel_frac_t wheel_frac(input wheel_mid_t m);
        logic signed [X_W-1:0] e_ext;
        logic signed [X_W-1:0] x;
        logic        [X_W-1:0] x_abs;
        wheel_frac_t           f;
        e_ext = {{(X_W-ERR_W){m.err[ERR_W-1]}}, m.err};
        x     = (e_ext <<< 4) + (e_ext <<< 3) + e_ext
              + {m.sum[SUM_W-1], m.sum, 1'b0};
        x_abs = x[X_W-1] ? -x : x;
        f.neg = x[X_W-1];
        f.big = (x_abs >= BIG_THRESH);
        f.mag = x_abs[MAG_W-1:0];
        return f;
    endfunction

    // Divide by 25 through the reciprocal, clamp to the limit, restore sign.
    function automatic logic [DRIVE_W-1:0] wheel_drive(
        input wheel_frac_t        f,
        input logic [LIMIT_W-1:0] lim
    );
        logic [PROD_W-1:0]  prod;
        logic [DRIVE_W-1:0] q;
        logic [DRIVE_W-1:0] qc;
        logic [DRIVE_W-1:0] lim_ext;
        prod    = {{(PROD_W-MAG_W){1'b0}}, f.mag} * RECIP_25;
        lim_ext = {1'b0, lim};
        q       = f.big ? 8'd128 : {1'b0, prod[RECIP_SHIFT+DRIVE_W-2:RECIP_SHIFT]};
        qc      = (q > lim_ext) ? lim_ext : q;
        return f.neg ? -qc : qc;
    endfunction

endpackage

// ----- rtl/dual_wheel_pi_speed_regulator.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_regulator
// Two-wheel PI speed loop with integral clearing on a sign reversal.
// ----------------------------------------------------------------------------
// One input beat is one control tick: left and right speed commands and the
// encoder tick counts of the last period. For each wheel the error is
// trunc(command/2 - ticks), added to a 32-bit error sum that saturates at
// +/-(2^31-1); the drive is trunc(error + 2*sum/25), clamped to
// +/-drive_limit. If either wheel's command points against its own sum, both
// sums are cleared before the tick is applied. While the output is not
// stalled the block takes one beat per clock, and it returns one result beat
// per input beat. A beat passes through the input register, the error/sum
// register, the sign/magnitude register and the output register, in that
// order. The rate is set by the sum update in the second stage: one 33-bit
// add and saturate per beat, with the sums fed straight back. A stalled
// output holds its beat while the stages behind it keep filling, so up to
// four beats are in flight. drive_limit resets to 100 and is written through
// cfg_we/cfg_wdata; the user must write it only while no beat is in flight,
// as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_regulator
    import dwpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beat
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] left_command, [31:16] right_command,
    // [47:32] left_ticks, [63:48] right_ticks
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result beat
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] left_drive, [15:8] right_drive
    output logic [OUT_DATA_W-1:0] m_tdata,
    // drive_limit register
    input  logic                  cfg_we,
    input  logic [LIMIT_W-1:0]    cfg_wdata
);

    // ---- Stage registers ---------------------------------------------------
    logic                  in_valid_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  mid_valid_reg;
    wheel_mid_t            mid_left_reg;
    wheel_mid_t            mid_right_reg;
    logic                  frac_valid_reg;
    wheel_frac_t           frac_left_reg;
    wheel_frac_t           frac_right_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // ---- Controller state ---------------------------------------------------
    logic signed [SUM_W-1:0] left_sum_reg;
    logic signed [SUM_W-1:0] right_sum_reg;
    logic [LIMIT_W-1:0]      limit_reg;

    // ---- Next values --------------------------------------------------------
    wheel_mid_t            mid_left_next;
    wheel_mid_t            mid_right_next;
    wheel_frac_t           frac_left_next;
    wheel_frac_t           frac_right_next;
    logic [OUT_DATA_W-1:0] out_data_next;

    // ---- Flow control -------------------------------------------------------
    logic out_ready;
    logic frac_ready;
    logic mid_ready;
    logic in_ready;
    logic in_load;
    logic mid_load;
    logic frac_load;
    logic out_load;

    logic signed [FIELD_W-1:0] left_command;
    logic signed [FIELD_W-1:0] right_command;
    logic signed [FIELD_W-1:0] left_ticks;
    logic signed [FIELD_W-1:0] right_ticks;
    logic                      clear_sums;

    // Each stage takes a beat when it is empty or its own beat moves on, so
    // a stalled output never stops the stages behind it from filling.
    assign out_ready  = !out_valid_reg  || m_tready;
    assign frac_ready = !frac_valid_reg || out_ready;
    assign mid_ready  = !mid_valid_reg  || frac_ready;
    assign in_ready   = !in_valid_reg   || mid_ready;

    assign in_load   = s_tvalid && in_ready;
    assign mid_load  = in_valid_reg && mid_ready;
    assign frac_load = mid_valid_reg && frac_ready;
    assign out_load  = frac_valid_reg && out_ready;

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack the held input beat.
    assign left_command  = in_data_reg[FIELD_W-1:0];
    assign right_command = in_data_reg[2*FIELD_W-1:FIELD_W];
    assign left_ticks    = in_data_reg[3*FIELD_W-1:2*FIELD_W];
    assign right_ticks   = in_data_reg[4*FIELD_W-1:3*FIELD_W];

    // Both checks look at the sums left by the previous tick.
    assign clear_sums = opposes(left_sum_reg, left_command)
                     || opposes(right_sum_reg, right_command);

    // Error and new sum per wheel; the sum also feeds back as state.
    always_comb begin
        mid_left_next.err  = wheel_error(left_command, left_ticks);
        mid_right_next.err = wheel_error(right_command, right_ticks);
        mid_left_next.sum  = sum_update(left_sum_reg, mid_left_next.err, clear_sums);
        mid_right_next.sum = sum_update(right_sum_reg, mid_right_next.err, clear_sums);
    end

    // Combine error and sum, keep sign and magnitude for the divide.
    always_comb begin
        frac_left_next  = wheel_frac(mid_left_reg);
        frac_right_next = wheel_frac(mid_right_reg);
    end

    // Divide by 25, clamp, pack the result beat.
    always_comb begin
        out_data_next = {wheel_drive(frac_right_reg, limit_reg),
                         wheel_drive(frac_left_reg, limit_reg)};
    end

    // ---- Control and state --------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mid_valid_reg  <= 1'b0;
            frac_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_sum_reg   <= '0;
            right_sum_reg  <= '0;
            limit_reg      <= DRIVE_LIMIT_RESET;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_ready) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (frac_ready) begin
                frac_valid_reg <= mid_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= frac_valid_reg;
            end
            // Advance the integrals exactly once per beat.
            if (mid_load) begin
                left_sum_reg  <= mid_left_next.sum;
                right_sum_reg <= mid_right_next.sum;
            end
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // ---- Payload ------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata;
        end
        if (mid_load) begin
            mid_left_reg  <= mid_left_next;
            mid_right_reg <= mid_right_next;
        end
        if (frac_load) begin
            frac_left_reg  <= frac_left_next;
            frac_right_reg <= frac_right_next;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/dwpi_checker.sv -----
// ----------------------------------------------------------------------------
// dwpi_checker
// Port-level checks on the regulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_wheel_pi_speed_regulator_assert.svh"

module dwpi_checker
    import dwpi_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  cfg_we,
    input logic [LIMIT_W-1:0]    cfg_wdata
);

    logic [LIMIT_W-1:0]        limit_reg;
    logic signed [DRIVE_W-1:0] lim_pos;
    logic signed [DRIVE_W-1:0] lim_neg;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      drives_in_range;

    // Track the drive limit as written at the port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= DRIVE_LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    assign lim_pos     = {1'b0, limit_reg};
    assign lim_neg     = -lim_pos;
    assign left_drive  = m_tdata[DRIVE_W-1:0];
    assign right_drive = m_tdata[2*DRIVE_W-1:DRIVE_W];
    assign drives_in_range = (left_drive <= lim_pos) && (left_drive >= lim_neg)
                          && (right_drive <= lim_pos) && (right_drive >= lim_neg);

    // A stalled result beat holds.
    `DWPI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every drive lies inside the configured clamp.
    `DWPI_ASSERT_SAME(a_drive_clamp, aclk, aresetn, m_tvalid, drives_in_range)

    // With the output empty nothing can hold back the input.
    `DWPI_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // Reset empties the pipeline.
    `DWPI_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind dual_wheel_pi_speed_regulator dwpi_checker u_dwpi_checker (.*);
